// File: hdl/r64dec_pkg.sv
`timescale 1ns / 1ps

package r64dec_pkg;

    // Width of the saturating byte counter.
    localparam int COUNT_WIDTH = 16;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // Character codes that bound each alphabet range.
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    // Sextet base values of each range.
    localparam logic [5:0] SX_UPPER_BASE = 6'h02;
    localparam logic [5:0] SX_LOWER_BASE = 6'h1C;
    localparam logic [5:0] SX_DIGIT_BASE = 6'h36;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_INVALID = 2'd1,
        STATUS_LONE    = 2'd2
    } status_t;

    typedef struct packed {
        logic [5:0] sextet;
        logic       bad;
    } sextet_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        done_res;
        status_t     status;
        logic [15:0] byte_total;
    } result_t;

endpackage

// File: hdl/r64dec_sextet.sv
`timescale 1ns / 1ps

module r64dec_sextet (
    input  logic [7:0]          ch,
    output r64dec_pkg::sextet_t code
);
    import r64dec_pkg::*;

    logic [7:0] off_upper;
    logic [7:0] off_lower;
    logic [7:0] off_digit;

    assign off_upper = ch - CH_UPPER_A;
    assign off_lower = ch - CH_LOWER_A;
    assign off_digit = ch - CH_DIGIT_0;

    always_comb
    begin
        code.sextet = '0;
        code.bad    = 1'b0;
        if (ch == CH_DOT)
        begin
            code.sextet = 6'd0;
        end
        else if (ch == CH_SLASH)
        begin
            code.sextet = 6'd1;
        end
        else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z)
        begin
            code.sextet = off_upper[5:0] + SX_UPPER_BASE;
        end
        else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z)
        begin
            code.sextet = off_lower[5:0] + SX_LOWER_BASE;
        end
        else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
        begin
            code.sextet = off_digit[5:0] + SX_DIGIT_BASE;
        end
        else
        begin
            code.bad = 1'b1;
        end
    end

endmodule

// File: hdl/radix64_decoder_bcrypt.sv
`timescale 1ns / 1ps

// Channel  | handshake             | payload
// ---------+-----------------------+----------------------------------------------
// input    | in_valid / in_stall   | ch[7:0], last
// output   | out_valid / out_stall | out_byte[7:0], byte_valid, done_res,
//          |                       | status[1:0], byte_total[15:0]
//
// One character per cycle while in_stall is low. Any result is registered
// in the result register, or in the skid entry while that is held. Decode
// and state update fit in one pass between the group state registers and
// the result register. A result register plus one skid entry sit on the
// output; input stalls only while the skid entry is occupied, so characters
// that make no result keep flowing under an output stall. Reset (rst_n,
// async low) clears group state and the valid flags of both output entries.

module radix64_decoder_bcrypt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        byte_valid,
    output logic        done_res,
    output logic [1:0]  status,
    output logic [15:0] byte_total
);
    import r64dec_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

    // group state
    logic [1:0]             group_pos_reg,  group_pos_next;
    logic [5:0]             carry_bits_reg, carry_bits_next;
    logic                   error_seen_reg, error_seen_next;
    logic [COUNT_WIDTH-1:0] byte_count_reg, byte_count_next;

    // output register and skid entry
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg,  out_data_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_data_reg,  skid_data_next;

    sextet_t                code;
    logic                   accept;
    logic                   err;
    logic                   have_byte;
    logic [7:0]             dec_byte;
    logic                   push;
    logic                   out_take;
    logic [EXT_W-1:0]       count_ext;
    result_t                res;

    r64dec_sextet u_sextet (
        .ch   (ch),
        .code (code)
    );

    assign in_stall = skid_valid_reg;
    assign accept   = in_valid && !skid_valid_reg;
    assign out_take = out_valid_reg && !out_stall;

    // decode step
    always_comb
    begin
        err             = error_seen_reg | code.bad;
        have_byte       = 1'b0;
        dec_byte        = 8'h00;
        carry_bits_next = carry_bits_reg;
        if (!err)
        begin
            case (group_pos_reg)
                2'd0:
                begin
                    carry_bits_next = code.sextet;
                end
                2'd1:
                begin
                    dec_byte        = {carry_bits_reg, code.sextet[5:4]};
                    carry_bits_next = {2'b00, code.sextet[3:0]};
                    have_byte       = 1'b1;
                end
                2'd2:
                begin
                    dec_byte        = {carry_bits_reg[3:0], code.sextet[5:2]};
                    carry_bits_next = {4'b0000, code.sextet[1:0]};
                    have_byte       = 1'b1;
                end
                default:
                begin
                    dec_byte        = {carry_bits_reg[1:0], code.sextet};
                    carry_bits_next = 6'd0;
                    have_byte       = 1'b1;
                end
            endcase
        end

        byte_count_next = byte_count_reg;
        if (have_byte && byte_count_reg != COUNT_MAX)
        begin
            byte_count_next = byte_count_reg + 1'b1;
        end

        count_ext      = EXT_W'(byte_count_next);
        res.out_byte   = dec_byte;
        res.byte_valid = have_byte;
        res.done_res   = last;
        if (!last)
        begin
            res.status = STATUS_OK;
        end
        else if (err)
        begin
            res.status = STATUS_INVALID;
        end
        else if (group_pos_reg == 2'd0)
        begin
            res.status = STATUS_LONE;
        end
        else
        begin
            res.status = STATUS_OK;
        end
        res.byte_total = count_ext[15:0];

        push = accept && (have_byte || last);

        group_pos_next  = group_pos_reg + 2'd1;
        error_seen_next = err;
        // string closed: start over
        if (last)
        begin
            group_pos_next  = 2'd0;
            carry_bits_next = 6'd0;
            error_seen_next = 1'b0;
            byte_count_next = '0;
        end
    end

    // output register / skid steering
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = push;
            out_data_next  = res;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_pos_reg  <= 2'd0;
            carry_bits_reg <= 6'd0;
            error_seen_reg <= 1'b0;
            byte_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                group_pos_reg  <= group_pos_next;
                carry_bits_reg <= carry_bits_next;
                error_seen_reg <= error_seen_next;
                byte_count_reg <= byte_count_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_data_reg.out_byte;
    assign byte_valid = out_data_reg.byte_valid;
    assign done_res   = out_data_reg.done_res;
    assign status     = out_data_reg.status;
    assign byte_total = out_data_reg.byte_total;

endmodule

// File: hdl/r64dec_checker.sv
`timescale 1ns / 1ps

module r64dec_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        byte_valid,
    input logic        done_res,
    input logic [1:0]  status,
    input logic [15:0] byte_total
);
    import r64dec_pkg::*;

    // input backs up only behind a full output register
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("stalled item dropped");

    // an item without a byte only closes a string
    a_no_byte_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> done_res)
        else $error("empty item that is not the last");

    a_status_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !done_res |-> status == STATUS_OK)
        else $error("status set before end of string");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> byte_total != 16'd0)
        else $error("byte delivered with zero total");

endmodule

bind radix64_decoder_bcrypt r64dec_checker u_r64dec_checker (.*);

// File: tb/sv/tb_radix64_decoder_bcrypt.sv
`timescale 1ns / 1ps

// Testbench for the bcrypt-alphabet radix-64 decoder.
// A behavioral decoder runs alongside the DUT: each accepted character is
// decoded here, and any result it causes is queued. Results leaving the DUT
// are popped from that queue in order and compared field by field.

module tb_radix64_decoder_bcrypt;

    import r64dec_pkg::*;

    localparam int DIR_ROWS     = 25;
    localparam int RANDOM_ITEMS = 700;
    // Characters in clean strings sent back to back at the end, with no idling.
    localparam int FINAL_ITEMS  = 80;
    localparam int LIMIT_CYCLES = 100000;

    // Directed row: the character, its last flag and, where the outcome is
    // obvious, the result typed in by hand.
    typedef struct packed {
        logic [7:0]  c;
        logic        l;
        logic        typed;
        logic [7:0]  e_byte;
        logic        e_bv;
        logic        e_done;
        status_t     e_st;
        logic [15:0] e_total;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'h00;
    logic        last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] byte_total;

    // Decoder state as the testbench sees it.
    logic [1:0]             grp_pos = '0;
    logic [5:0]             carry = '0;
    logic                   err_flag = 1'b0;
    logic [COUNT_WIDTH-1:0] nbytes = '0;

    result_t     pending_decodes[$];
    dir_row_t    dir_tab[DIR_ROWS];

    bit          gaps_on = 1'b1;
    bit          stalls_on = 1'b1;
    int unsigned stall_left = 0;
    int unsigned mismatches = 0;
    int unsigned chars_sent = 0;
    int unsigned strings_sent = 0;
    int unsigned results_seen = 0;
    int unsigned longest = 0;
    int unsigned cycles = 0;

    radix64_decoder_bcrypt dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .done_res   (done_res),
        .status     (status),
        .byte_total (byte_total)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_decodes.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        mismatches++;
        $display("mismatch @%0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] wanted);
        if (got !== wanted)
            flag_error($sformatf("result %0d %s: got %0h, expected %0h",
                                 results_seen, name, got, wanted));
    endtask

    // Behavioral decode of one character. Returns 1 when it yields a result.
    function automatic bit decode_char(input logic [7:0] c, input logic l,
                                       output result_t r);
        logic [5:0] sx;
        logic       bad;
        logic       got_byte;
        logic [7:0] b;
        logic [1:0] pos;
        sx = '0;
        bad = 1'b0;
        got_byte = 1'b0;
        b = '0;
        pos = grp_pos;
        if (c == CH_DOT)
            sx = 6'd0;
        else if (c == CH_SLASH)
            sx = 6'd1;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            sx = 6'(c - CH_UPPER_A + SX_UPPER_BASE);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_Z)
            sx = 6'(c - CH_LOWER_A + SX_LOWER_BASE);
        else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            sx = 6'(c - CH_DIGIT_0 + SX_DIGIT_BASE);
        else
            bad = 1'b1;

        // sticky: the offending character itself already blocks output
        if (bad)
            err_flag = 1'b1;

        if (!err_flag)
        begin
            case (pos)
                2'd0:
                begin
                    carry = sx;
                end
                2'd1:
                begin
                    b = {carry, sx[5:4]};
                    carry = {2'b00, sx[3:0]};
                    got_byte = 1'b1;
                end
                2'd2:
                begin
                    b = {carry[3:0], sx[5:2]};
                    carry = {4'b0000, sx[1:0]};
                    got_byte = 1'b1;
                end
                default:
                begin
                    b = {carry[1:0], sx};
                    carry = '0;
                    got_byte = 1'b1;
                end
            endcase
            if (got_byte && nbytes != COUNT_MAX)
                nbytes = nbytes + 1'b1;
        end
        grp_pos = pos + 2'd1;

        r.out_byte   = got_byte ? b : 8'h00;
        r.byte_valid = got_byte;
        r.done_res   = l;
        r.status     = STATUS_OK;
        r.byte_total = 16'(nbytes);
        if (l)
        begin
            if (err_flag)
                r.status = STATUS_INVALID;
            else if (pos == 2'd0)
                r.status = STATUS_LONE;
            // string closed: start clean
            grp_pos = '0;
            carry = '0;
            err_flag = 1'b0;
            nbytes = '0;
        end
        return got_byte || l;
    endfunction

    // Alphabet symbol for a sextet value.
    function automatic logic [7:0] symbol_of(input logic [5:0] v);
        if (v == 6'd0)
            return CH_DOT;
        if (v == 6'd1)
            return CH_SLASH;
        if (v < SX_LOWER_BASE)
            return CH_UPPER_A + (v - SX_UPPER_BASE);
        if (v < SX_DIGIT_BASE)
            return CH_LOWER_A + (v - SX_LOWER_BASE);
        return CH_DIGIT_0 + (v - SX_DIGIT_BASE);
    endfunction

    // Drives one character and waits for its acceptance. Starts and ends
    // away from the falling edge so valid is never dropped and raised in
    // one step. A typed row overrides the computed expectation.
    task automatic send_char(input logic [7:0] c, input logic l, input logic typed,
                             input result_t want);
        int unsigned gap;
        result_t     calc;
        bit          has;
        gap = (gaps_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        ch <= c;
        last <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        has = decode_char(c, l, calc);
        if (typed)
            pending_decodes.push_back(want);
        else if (has)
            pending_decodes.push_back(calc);
        chars_sent++;
    endtask

    // Mostly well-formed strings; noisy ones drop arbitrary codes in.
    task automatic send_string(input int unsigned len, input bit noisy);
        logic [7:0] c;
        result_t    none;
        none = '0;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 4) == 0)
                c = 8'($urandom_range(0, 255));
            else
                c = symbol_of(6'($urandom_range(0, 63)));
            send_char(c, i == len - 1, 1'b0, none);
        end
        strings_sent++;
        if (len > longest)
            longest = len;
    endtask

    // Sender holds off until every queued result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
    endtask

    // Output back-pressure, applied in bursts.
    always @(negedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Result checker: every accepted result must match the oldest expectation.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
                flag_error($sformatf("unexpected result byte=%02h valid=%0b done=%0b",
                                     out_byte, byte_valid, done_res));
            else
            begin
                want = pending_decodes.pop_front();
                check_field("out_byte", 16'(out_byte), 16'(want.out_byte));
                check_field("byte_valid", 16'(byte_valid), 16'(want.byte_valid));
                check_field("done_res", 16'(done_res), 16'(want.done_res));
                check_field("status", 16'(status), 16'(want.status));
                check_field("byte_total", byte_total, want.byte_total);
            end
            results_seen++;
        end
    end

    initial
    begin
        result_t     want;
        int unsigned rand_chars;
        int unsigned len;
        bit          noisy;

        // lone character at the start of a group
        dir_tab[0]  = '{CH_DOT,     1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_LONE,    16'd0};
        // lowest sextet: a full group of zero bytes
        dir_tab[1]  = '{CH_DOT,     1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[2]  = '{CH_DOT,     1'b0, 1'b1, 8'h00, 1'b1, 1'b0, STATUS_OK,      16'd1};
        dir_tab[3]  = '{CH_DOT,     1'b0, 1'b1, 8'h00, 1'b1, 1'b0, STATUS_OK,      16'd2};
        dir_tab[4]  = '{CH_DOT,     1'b0, 1'b1, 8'h00, 1'b1, 1'b0, STATUS_OK,      16'd3};
        // highest sextet: all-ones bytes, closes on a full group
        dir_tab[5]  = '{CH_DIGIT_9, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[6]  = '{CH_DIGIT_9, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, STATUS_OK,      16'd4};
        dir_tab[7]  = '{CH_DIGIT_9, 1'b0, 1'b1, 8'hFF, 1'b1, 1'b0, STATUS_OK,      16'd5};
        dir_tab[8]  = '{CH_DIGIT_9, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, STATUS_OK,      16'd6};
        // range edges, then a partial group of two
        dir_tab[9]  = '{CH_UPPER_A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[10] = '{CH_UPPER_Z, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[11] = '{CH_LOWER_A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[12] = '{CH_LOWER_Z, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[13] = '{CH_DIGIT_0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[14] = '{CH_SLASH,   1'b1, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        // invalid lone character beats the lone-character status
        dir_tab[15] = '{8'h2D,      1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_INVALID, 16'd0};
        // invalid mid-group, string continues to an invalid last
        dir_tab[16] = '{CH_UPPER_A, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[17] = '{8'h3A,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[18] = '{"B",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[19] = '{8'hFF,      1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_INVALID, 16'd0};
        // one good byte, then an error freezes the count at 1
        dir_tab[20] = '{"m",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[21] = '{"Q",        1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[22] = '{8'h5B,      1'b0, 1'b0, 8'h00, 1'b0, 1'b0, STATUS_OK,      16'd0};
        dir_tab[23] = '{8'h60,      1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_INVALID, 16'd1};
        dir_tab[24] = '{8'h7B,      1'b1, 1'b1, 8'h00, 1'b0, 1'b1, STATUS_INVALID, 16'd0};

        // single reset at the start
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            want.out_byte   = dir_tab[i].e_byte;
            want.byte_valid = dir_tab[i].e_bv;
            want.done_res   = dir_tab[i].e_done;
            want.status     = dir_tab[i].e_st;
            want.byte_total = dir_tab[i].e_total;
            send_char(dir_tab[i].c, dir_tab[i].l, dir_tab[i].typed, want);
            if (dir_tab[i].l)
                strings_sent++;
        end
        wait_drained();

        // random strings, idling switched per string
        rand_chars = 0;
        while (rand_chars < RANDOM_ITEMS)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            noisy = ($urandom_range(0, 3) == 0);
            gaps_on = ($urandom_range(0, 3) != 0);
            stalls_on = ($urandom_range(0, 3) != 0);
            send_string(len, noisy);
            rand_chars += len;
            if ($urandom_range(0, 7) == 0)
                wait_drained();
        end

        // final stretch at full rate: let any stall burst run out first
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        wait_drained();
        repeat (12) @(negedge clk);
        rand_chars = 0;
        while (rand_chars < FINAL_ITEMS)
        begin
            len = $urandom_range(1, 12);
            send_string(len, 1'b0);
            rand_chars += len;
        end

        wait_drained();
        repeat (8) @(posedge clk);

        $display("run: %0d characters in %0d strings, %0d results compared",
                 chars_sent, strings_sent, results_seen);
        $display("run: longest string %0d characters, last stretch back to back", longest);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
